>>> hw/rtl/screen_token_classifier_unit_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the screen token classifier
// Clocked on clk, quiet while rst_n is low. Define NO_ASSERTIONS to drop them.
// ----------------------------------------------------------------------------
`ifndef SCREEN_TOKEN_CLASSIFIER_UNIT_ASSERT_SVH
`define SCREEN_TOKEN_CLASSIFIER_UNIT_ASSERT_SVH

`ifndef NO_ASSERTIONS

`define STCU_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`define STCU_ASSERT_NEXT(lbl, cond, res, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (res)) \
        else $error(msg);

`else

`define STCU_ASSERT(lbl, prop, msg)

`define STCU_ASSERT_NEXT(lbl, cond, res, msg)

`endif

`endif

>>> hw/rtl/stc_pkg.sv
// ----------------------------------------------------------------------------
// Screen token classifier package
// Constants, pattern tables and character class functions.
// ----------------------------------------------------------------------------
package stc_pkg;

    localparam int MAX_TOKENS  = 16;
    localparam int SCREEN_ROWS = 256;
    localparam int SCREEN_COLS = 256;
    localparam int WORD_BUFFER = 256;

    localparam int NUM_PATTERNS = 11;
    localparam int PAT_CHARS    = 8;
    localparam int UUID_BIT     = 6;

    localparam logic [7:0] MIN_WORD    = 8'd4;

    localparam logic [NUM_PATTERNS-1:0] ALL_ALIVE = '1;

    typedef enum logic [1:0] {
        TYPE_URL  = 2'd0,
        TYPE_IP   = 2'd1,
        TYPE_UUID = 2'd2,
        TYPE_PATH = 2'd3
    } token_type_t;

    typedef logic [7:0] pat_row_t [PAT_CHARS];

    localparam pat_row_t PAT_TEXT [NUM_PATTERNS] = '{
        '{"h", "t", "t", "p", ":", "/", "/", 8'h00},
        '{"h", "t", "t", "p", "s", ":", "/", "/"},
        '{"1", "9", "2", ".", "1", "6", "8", "."},
        '{"1", "0", ".", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"1", "7", "2", ".", 8'h00, 8'h00, 8'h00, 8'h00},
        '{"1", "2", "7", ".", "0", ".", 8'h00, 8'h00},
        '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"/", "h", "o", "m", "e", 8'h00, 8'h00, 8'h00},
        '{"/", "v", "a", "r", 8'h00, 8'h00, 8'h00, 8'h00},
        '{"/", "e", "t", "c", 8'h00, 8'h00, 8'h00, 8'h00},
        '{"/", "t", "m", "p", 8'h00, 8'h00, 8'h00, 8'h00}
    };

    localparam logic [7:0] PAT_LEN [NUM_PATTERNS] = '{
        8'd7, 8'd8, 8'd8, 8'd3, 8'd4, 8'd6, 8'd36, 8'd5, 8'd4, 8'd4, 8'd4
    };

    typedef struct packed {
        logic [7:0] ch;
        logic [7:0] row;
        logic [7:0] col;
        logic       end_of_row;
        logic       start_of_screen;
    } cell_t;

    function automatic logic is_hex(input logic [7:0] c);
        return (c >= "0" && c <= "9") || (c >= "a" && c <= "f") ||
               (c >= "A" && c <= "F");
    endfunction

    function automatic logic is_word_char(input logic [7:0] c);
        return (c >= "0" && c <= "9") || (c >= "a" && c <= "z") ||
               (c >= "A" && c <= "Z") || c == "." || c == "/" || c == "-" ||
               c == "_" || c == ":" || c == "?" || c == "=" || c == "&" ||
               c == "%" || c == "~";
    endfunction

endpackage

>>> hw/rtl/stc_cell_if.sv
// ----------------------------------------------------------------------------
// Screen cell channel
// Valid/ready channel carrying one screen cell per transfer.
// ----------------------------------------------------------------------------
interface stc_cell_if;
    logic       valid;
    logic       ready;
    logic [7:0] ch;
    logic [7:0] row;
    logic [7:0] col;
    logic       end_of_row;
    logic       start_of_screen;

    modport source (output valid, ch, row, col, end_of_row, start_of_screen,
                    input ready);
    modport sink   (input valid, ch, row, col, end_of_row, start_of_screen,
                    output ready);
endinterface

>>> hw/rtl/stc_token_if.sv
// ----------------------------------------------------------------------------
// Token channel
// Valid/ready channel carrying one detected token per transfer.
// ----------------------------------------------------------------------------
interface stc_token_if;
    logic       valid;
    logic       ready;
    logic [4:0] token_num;
    logic [1:0] token_type;
    logic [7:0] token_row;
    logic [7:0] token_col;
    logic [7:0] token_length;

    modport source (output valid, token_num, token_type, token_row, token_col,
                    token_length, input ready);
    modport sink   (input valid, token_num, token_type, token_row, token_col,
                    token_length, output ready);
endinterface

>>> hw/rtl/stc_match.sv
// ----------------------------------------------------------------------------
// Pattern matcher
// Checks one word character against each pattern whose length reaches past its
// position in the word and clears the alive bit of each pattern that no longer fits.
// ----------------------------------------------------------------------------
module stc_match (
    input  logic [7:0]                       ch,
    input  logic [7:0]                       pos,
    input  logic [stc_pkg::NUM_PATTERNS-1:0] alive,
    output logic [stc_pkg::NUM_PATTERNS-1:0] alive_out
);

    logic uuid_dash;

    assign uuid_dash = (pos == 8'd8) || (pos == 8'd13) || (pos == 8'd18) ||
                       (pos == 8'd23);

    always_comb
    begin
        alive_out = alive;
        for (int p = 0; p < stc_pkg::NUM_PATTERNS; p++)
        begin
            if (pos < stc_pkg::PAT_LEN[p])
            begin
                if (p == stc_pkg::UUID_BIT)
                begin
                    if (uuid_dash ? (ch != "-") : !stc_pkg::is_hex(ch))
                        alive_out[p] = 1'b0;
                end
                else if (stc_pkg::PAT_TEXT[p][pos[2:0]] != ch)
                begin
                    alive_out[p] = 1'b0;
                end
            end
        end
    end

endmodule

>>> hw/rtl/screen_token_classifier_unit.sv
// ----------------------------------------------------------------------------
// Screen token classifier
// A cell transfer fills the input register; its token is then registered on the output.
// Throughput: one cell per cycle; the word update and classification of a
// cell sit in one stage between the input register and the token register.
// A token held on the output stalls the next cell until it is taken.
// Reset: asynchronous, active low; clears word state, token count and valids.
// ----------------------------------------------------------------------------
`include "screen_token_classifier_unit_assert.svh"

module screen_token_classifier_unit #(
    parameter int MAX_TOKENS  = stc_pkg::MAX_TOKENS,
    parameter int SCREEN_ROWS = stc_pkg::SCREEN_ROWS,
    parameter int SCREEN_COLS = stc_pkg::SCREEN_COLS,
    parameter int WORD_BUFFER = stc_pkg::WORD_BUFFER
) (
    input  logic              clk,
    input  logic              rst_n,
    stc_cell_if.sink          cells,
    stc_token_if.source       tokens
);

    localparam int NP = stc_pkg::NUM_PATTERNS;

    localparam logic [7:0] WORD_CAP    = 8'((WORD_BUFFER - 1 > 255) ? 255 : WORD_BUFFER - 1);
    localparam logic [4:0] TOKEN_LIMIT = 5'((MAX_TOKENS < 31) ? MAX_TOKENS : 31);
    localparam logic [8:0] ROW_LIMIT   = 9'(SCREEN_ROWS);
    localparam logic [8:0] COL_LIMIT   = 9'(SCREEN_COLS);

    logic                  in_valid_reg;
    stc_pkg::cell_t        cell_reg;
    logic                  fire;

    logic [7:0]            word_len_reg,   word_len_next;
    logic [7:0]            start_col_reg,  start_col_next;
    logic [NP-1:0]         alive_reg,      alive_next;
    logic [4:0]            count_reg,      count_next;

    logic                  out_valid_reg;
    logic [4:0]            id_reg;
    stc_pkg::token_type_t  type_reg;
    logic [7:0]            trow_reg;
    logic [7:0]            tcol_reg;
    logic [7:0]            tlen_reg;

    logic [4:0]            cnt0;
    logic [7:0]            len0;
    logic [NP-1:0]         alive0;
    logic [NP-1:0]         alive1;
    logic [NP-1:0]         alive_upd;
    logic [NP-1:0]         alive2;
    logic [7:0]            len1;
    logic                  is_word;
    logic                  finish;
    logic [NP-1:0]         hit;
    logic                  emit;
    stc_pkg::token_type_t  type_sel;

    assign fire        = in_valid_reg && (!out_valid_reg || tokens.ready);
    assign cells.ready = !in_valid_reg || fire;

    stc_match u_match (
        .ch        (cell_reg.ch),
        .pos       (len0),
        .alive     (alive1),
        .alive_out (alive_upd)
    );

    always_comb
    begin
        cnt0   = cell_reg.start_of_screen ? 5'd0 : count_reg;
        len0   = cell_reg.start_of_screen ? 8'd0 : word_len_reg;
        alive0 = cell_reg.start_of_screen ? stc_pkg::ALL_ALIVE : alive_reg;

        is_word = ({1'b0, cell_reg.row} < ROW_LIMIT) &&
                  ({1'b0, cell_reg.col} < COL_LIMIT) &&
                  stc_pkg::is_word_char(cell_reg.ch);

        alive1         = (len0 == 8'd0) ? stc_pkg::ALL_ALIVE : alive0;
        start_col_next = start_col_reg;
        alive2         = alive0;
        len1           = len0;
        if (is_word)
        begin
            if (len0 == 8'd0)
                start_col_next = cell_reg.col;
            if (len0 < WORD_CAP)
            begin
                alive2 = alive_upd;
                len1   = len0 + 8'd1;
            end
            else
            begin
                alive2 = alive1;
            end
        end

        finish = (cell_reg.end_of_row || !is_word) && (len1 != 8'd0);

        for (int p = 0; p < NP; p++)
            hit[p] = alive2[p] && (len1 >= stc_pkg::PAT_LEN[p]);

        type_sel = stc_pkg::TYPE_PATH;
        priority if (hit[0] || hit[1])
            type_sel = stc_pkg::TYPE_URL;
        else if (hit[2] || hit[3] || hit[4] || hit[5])
            type_sel = stc_pkg::TYPE_IP;
        else if (hit[stc_pkg::UUID_BIT])
            type_sel = stc_pkg::TYPE_UUID;
        else
            type_sel = stc_pkg::TYPE_PATH;

        emit = finish && (len1 >= stc_pkg::MIN_WORD) &&
               (cnt0 < TOKEN_LIMIT) && (hit != '0);

        if (finish)
        begin
            word_len_next = 8'd0;
            alive_next    = stc_pkg::ALL_ALIVE;
        end
        else
        begin
            word_len_next = len1;
            alive_next    = alive2;
        end
        count_next = emit ? cnt0 + 5'd1 : cnt0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            word_len_reg  <= 8'd0;
            start_col_reg <= 8'd0;
            alive_reg     <= stc_pkg::ALL_ALIVE;
            count_reg     <= 5'd0;
        end
        else
        begin
            if (cells.ready)
                in_valid_reg <= cells.valid;
            if (fire)
            begin
                word_len_reg  <= word_len_next;
                start_col_reg <= start_col_next;
                alive_reg     <= alive_next;
                count_reg     <= count_next;
            end
            if (fire && emit)
                out_valid_reg <= 1'b1;
            else if (tokens.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cells.ready && cells.valid)
        begin
            cell_reg.ch              <= cells.ch;
            cell_reg.row             <= cells.row;
            cell_reg.col             <= cells.col;
            cell_reg.end_of_row      <= cells.end_of_row;
            cell_reg.start_of_screen <= cells.start_of_screen;
        end
        if (fire && emit)
        begin
            id_reg   <= cnt0 + 5'd1;
            type_reg <= type_sel;
            trow_reg <= cell_reg.row;
            tcol_reg <= start_col_next;
            tlen_reg <= len1;
        end
    end

    assign tokens.valid        = out_valid_reg;
    assign tokens.token_num    = id_reg;
    assign tokens.token_type   = type_reg;
    assign tokens.token_row    = trow_reg;
    assign tokens.token_col    = tcol_reg;
    assign tokens.token_length = tlen_reg;

    // word state and token budget
    `STCU_ASSERT(a_idle_word_alive, (word_len_reg != 8'd0) || (alive_reg == stc_pkg::ALL_ALIVE), "alive bits dirty with no open word")
    `STCU_ASSERT(a_count_limit, count_reg <= TOKEN_LIMIT, "token count beyond limit")
    `STCU_ASSERT(a_token_shape, !tokens.valid || ((tokens.token_length >= stc_pkg::MIN_WORD) && (tokens.token_num != 5'd0)), "malformed token on output")
    `STCU_ASSERT_NEXT(a_emit_shown, fire && emit, tokens.valid, "emitted token not presented")

endmodule
